FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the square root loop.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/nsqrt_pkg.sv
// Package with register codes and fixed constants of the square root loop.
`timescale 1ns / 1ps
`default_nettype none

package nsqrt_pkg;

   // Fixed field widths
   localparam int EPS_WIDTH  = 32;
   localparam int STEP_WIDTH = 8;

   // Register reset values
   localparam logic [EPS_WIDTH-1:0]  EPS_RESET      = 32'd429497;
   localparam logic [STEP_WIDTH-1:0] MAX_ITER_RESET = 8'd64;

   // Register index codes
   localparam logic [1:0] REG_EPSILON  = 2'd0;
   localparam logic [1:0] REG_INIT_EST = 2'd1;
   localparam logic [1:0] REG_MAX_ITER = 2'd2;

   typedef logic [STEP_WIDTH-1:0] step_type;

endpackage

`default_nettype wire

FILE: rtl/newton_square_root_loop.sv
// Newton-Raphson square root loop: sequencer around one shared add/subtract unit.
// Each Newton step runs a check (shift-add square, difference, compare) and then a
// restoring divide; one item is in work at a time.
// The bit-serial divider and squarer share one adder and set the rate.
// Reset (synchronous, active high) restores register defaults and the estimate.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module newton_square_root_loop
   import nsqrt_pkg::*;
#(
   parameter int DATA_WIDTH    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // bits from 0: radicand
   input  wire  [((DATA_WIDTH+7)/8)*8-1:0]  req_tdata,
   // result channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // bits from 0: root, steps_taken
   output logic [((DATA_WIDTH+15)/8)*8-1:0] rsp_tdata,
   // bit 0: converged
   output logic                             rsp_tuser,
   // configuration port
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [(DATA_WIDTH > 32 ? 3 : 2)+1:0] csr_paddr,
   input  wire  [(DATA_WIDTH > 32 ? 64 : 32)-1:0] csr_pwdata,
   output logic [(DATA_WIDTH > 32 ? 64 : 32)-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int DW       = DATA_WIDTH;
   localparam int FW       = FRACTION_BITS;
   localparam int NW       = DW + FW;
   localparam int AW       = ((2 * DW > NW) ? 2 * DW : NW) + 1;
   localparam int CW       = $clog2(NW);
   localparam int CSR_W    = (DW > 32) ? 64 : 32;
   localparam int ADDR_LSB = (DW > 32) ? 3 : 2;
   localparam int RSP_W    = ((DW + 15) / 8) * 8;
   localparam logic [DW-1:0] INIT_RESET = DW'(64'd2 << FW);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_UPDATE = 3'd6;

   // Configuration registers
   logic [EPS_WIDTH-1:0] eps_ff;
   logic [DW-1:0]        init_ff;
   step_type             max_ff;

   // Sequencer and datapath state
   logic [2:0]    state_ff, state_in;
   logic [DW-1:0] est_ff, est_in;
   logic [DW-1:0] rad_ff, rad_in;
   step_type      step_ff, step_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [NW-1:0] qt_ff, qt_in;
   logic [CW-1:0] bit_ff, bit_in;
   logic          final_ff, final_in;
   logic          ok_ff, ok_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_root_ff, rsp_root_in;
   step_type      rsp_steps_ff, rsp_steps_in;
   logic          rsp_conv_ff, rsp_conv_in;

   // Shared adder
   logic [AW-1:0] add_a, add_b, add_sum;
   logic          add_c;

   // Local terms
   logic [DW:0]   div_sh;
   logic          div_ge;
   logic [AW-1:0] target, square;
   logic [DW-1:0] q_sat, nxt;
   logic [DW:0]   nsum;
   logic          emit_go;
   logic          cfg_wr;
   logic [1:0]    cfg_idx;

   function automatic logic [DW-1:0] nonzero(input logic [DW-1:0] e, input logic [DW-1:0] init);
      logic [DW-1:0] r;
      if (e != '0) begin
         r = e;
      end else if (init != '0) begin
         r = init;
      end else begin
         r = DW'(1);
      end
      return r;
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[ADDR_LSB+1:ADDR_LSB];
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff  <= EPS_RESET;
         init_ff <= INIT_RESET;
         max_ff  <= MAX_ITER_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_EPSILON:  eps_ff  <= csr_pwdata[EPS_WIDTH-1:0];
            REG_INIT_EST: init_ff <= csr_pwdata[DW-1:0];
            REG_MAX_ITER: max_ff  <= csr_pwdata[STEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_EPSILON:  csr_prdata = CSR_W'(eps_ff);
         REG_INIT_EST: csr_prdata = CSR_W'(init_ff);
         REG_MAX_ITER: csr_prdata = CSR_W'(max_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Shared add unit: shift-add for the square, trial subtract for the divide
   assign div_sh = {acc_ff[DW-1:0], qt_ff[NW-1]};

   always_comb begin
      case (state_ff)
         S_MUL: begin
            add_a = acc_ff << 1;
            add_b = qt_ff[NW-1] ? AW'(est_ff) : '0;
            add_c = 1'b0;
         end
         S_DIV: begin
            add_a = AW'(div_sh);
            add_b = ~AW'(est_ff);
            add_c = 1'b1;
         end
         default: begin
            add_a = '0;
            add_b = '0;
            add_c = 1'b0;
         end
      endcase
   end

   assign add_sum = add_a + add_b + AW'(add_c);
   assign div_ge  = ~add_sum[AW-1];

   // Check terms and step update terms
   assign target = AW'(rad_ff) << FW;
   assign square = acc_ff;
   assign q_sat  = (qt_ff[NW-1:DW] != '0) ? {DW{1'b1}} : qt_ff[DW-1:0];
   assign nsum   = {1'b0, q_sat} + {1'b0, est_ff};
   assign nxt    = nsum[DW:1];

   assign emit_go    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      est_in       = est_ff;
      rad_in       = rad_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      qt_in        = qt_ff;
      bit_in       = bit_ff;
      final_in     = final_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_root_in  = rsp_root_ff;
      rsp_steps_in = rsp_steps_ff;
      rsp_conv_in  = rsp_conv_ff;
      case (state_ff)
         S_IDLE: begin
            // take a request and start squaring the estimate
            if (req_tvalid) begin
               rad_in   = req_tdata[DW-1:0];
               step_in  = '0;
               final_in = 1'b0;
               est_in   = nonzero(est_ff, init_ff);
               acc_in   = '0;
               qt_in    = {nonzero(est_ff, init_ff), {FW{1'b0}}};
               bit_in   = CW'(DW - 1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in = add_sum;
            qt_in  = qt_ff << 1;
            if (bit_ff == '0) begin
               state_in = S_CHECK;
            end else begin
               bit_in = bit_ff - CW'(1);
            end
         end
         S_CHECK: begin
            // absolute difference of target and square
            acc_in   = (target >= square) ? target - square : square - target;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ok_in = (acc_ff < AW'(eps_ff));
            if ((acc_ff < AW'(eps_ff)) || (step_ff >= max_ff)) begin
               state_in = S_EMIT;
            end else begin
               acc_in   = '0;
               qt_in    = {rad_ff, {FW{1'b0}}};
               bit_in   = CW'(NW - 1);
               state_in = S_DIV;
            end
         end
         S_EMIT: begin
            // hand off the result, then run the extra step
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = est_ff;
               rsp_steps_in = step_ff;
               rsp_conv_in  = ok_ff;
               final_in     = 1'b1;
               acc_in       = '0;
               qt_in        = {rad_ff, {FW{1'b0}}};
               bit_in       = CW'(NW - 1);
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            acc_in = div_ge ? add_sum : AW'(div_sh);
            qt_in  = {qt_ff[NW-2:0], div_ge};
            if (bit_ff == '0) begin
               state_in = S_UPDATE;
            end else begin
               bit_in = bit_ff - CW'(1);
            end
         end
         S_UPDATE: begin
            est_in = nonzero(nxt, init_ff);
            if (final_ff) begin
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + STEP_WIDTH'(1);
               acc_in   = '0;
               qt_in    = {nonzero(nxt, init_ff), {FW{1'b0}}};
               bit_in   = CW'(DW - 1);
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         est_ff       <= INIT_RESET;
         step_ff      <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         step_ff      <= step_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rad_ff       <= rad_in;
      acc_ff       <= acc_in;
      qt_ff        <= qt_in;
      bit_ff       <= bit_in;
      ok_ff        <= ok_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_steps_ff <= rsp_steps_in;
      rsp_conv_ff  <= rsp_conv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_steps_ff, rsp_root_ff});
   assign rsp_tuser  = rsp_conv_ff;

   // Checks
   `ASSERT_NEXT(a_accept_starts_square, clock, reset, req_tvalid && req_tready, state_ff == S_MUL)
   `ASSERT_NEXT(a_emit_loads_result, clock, reset, state_ff == S_EMIT && emit_go, rsp_tvalid)
   `ASSERT_SAME(a_divisor_nonzero, clock, reset, state_ff == S_DIV || state_ff == S_MUL, est_ff != '0)

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for the Newton square root loop: radicands checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb;
   import nsqrt_pkg::*;

   localparam int DW     = 32;
   localparam int FB     = 16;
   localparam int REQ_W  = ((DW + 7) / 8) * 8;
   localparam int RSP_W  = ((DW + 15) / 8) * 8;
   localparam int ADDR_W = (DW > 32 ? 3 : 2) + 2;
   localparam int CSR_W  = DW > 32 ? 64 : 32;
   localparam logic [DW-1:0] INIT_EST_RESET = 32'd131072;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 3000;
   localparam int HOLD_AFTER    = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 168;

   // pacing of the two channels
   typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_type;

   typedef struct packed {
      logic [DW-1:0] root;
      step_type      steps_taken;
      logic          converged;
   } root_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   wire               req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   wire               rsp_tvalid;
   logic              rsp_tready = 1'b0;
   wire  [RSP_W-1:0]  rsp_tdata;
   wire               rsp_tuser;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]  csr_pwdata = '0;
   wire  [CSR_W-1:0]  csr_prdata;
   wire               csr_pready;

   // predictor copy of the registers and the running estimate
   logic [31:0]   tolerance_setting = EPS_RESET;
   logic [DW-1:0] start_setting = INIT_EST_RESET;
   step_type      step_cap_setting = MAX_ITER_RESET;
   logic [DW-1:0] running_estimate = INIT_EST_RESET;

   logic [DW-1:0]   radicand_backlog[$];
   root_result_type pending_roots[$];
   pace_type        pace = PACE_SLOW_SINK;
   int              fail_count = 0;
   int              results_seen = 0;
   longint          cycle_limit = 10000;

   newton_square_root_loop #(
      .DATA_WIDTH(DW),
      .FRACTION_BITS(FB)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // substitute the start value (or one) for a zero estimate
   function automatic logic [DW-1:0] nonzero_guess(input logic [DW-1:0] guess);
      if (guess != '0) return guess;
      if (start_setting != '0) return start_setting;
      return DW'(1);
   endfunction

   function automatic logic [DW-1:0] newton_next(input logic [DW-1:0] rad,
                                                 input logic [DW-1:0] guess);
      logic [63:0] quotient;
      logic [63:0] average;
      quotient = {16'h0, rad, 16'h0} / {32'h0, guess};
      if (quotient > 64'hFFFF_FFFF) quotient = 64'hFFFF_FFFF;
      average = (quotient + {32'h0, guess}) >> 1;
      if (average > 64'hFFFF_FFFF) average = 64'hFFFF_FFFF;
      return average[DW-1:0];
   endfunction

   // compare radicand and estimate squared at Q32.32
   function automatic bit close_enough(input logic [DW-1:0] rad, input logic [DW-1:0] guess);
      logic [63:0] target;
      logic [63:0] square;
      logic [63:0] gap;
      target = {16'h0, rad, 16'h0};
      square = {32'h0, guess} * {32'h0, guess};
      gap = target >= square ? target - square : square - target;
      return gap < {32'h0, tolerance_setting};
   endfunction

   function automatic root_result_type predict_root(input logic [DW-1:0] rad);
      root_result_type outcome;
      logic [DW-1:0]   guess;
      int              steps;
      bit              ok;
      guess = nonzero_guess(running_estimate);
      steps = 0;
      ok = close_enough(rad, guess);
      while (!ok && steps < int'(step_cap_setting)) begin
         guess = nonzero_guess(newton_next(rad, guess));
         steps++;
         ok = close_enough(rad, guess);
      end
      outcome.root = guess;
      outcome.steps_taken = step_type'(steps);
      outcome.converged = ok;
      // carry one more step into the next request
      running_estimate = nonzero_guess(newton_next(rad, guess));
      return outcome;
   endfunction

   function automatic logic [DW-1:0] pick_radicand();
      logic [63:0] exact_root;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return $urandom >> $urandom_range(0, 31);
         7: begin
            // perfect square, so an exact root exists
            exact_root = 64'($urandom_range(0, 65535)) << 8;
            return 32'((exact_root * exact_root) >> 16);
         end
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'h0;
               1: return 32'h1;
               2: return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(0, 32'h000F_FFFF);
      endcase
   endfunction

   // drive requests from the backlog and predict each accepted one
   always @(posedge clock) begin : request_driver
      bit pause;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_roots.push_back(predict_root(req_tdata[DW-1:0]));
         end
         if (!req_tvalid || req_tready) begin
            case (pace)
               PACE_SLOW_SINK: pause = $urandom_range(0, 99) < 37;
               PACE_SLOW_SOURCE: pause = $urandom_range(0, 99) < 86;
               default: pause = 1'b0;
            endcase
            if (radicand_backlog.size() > 0 && !pause) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_W'(radicand_backlog.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check results and pace the result channel
   always @(posedge clock) begin : result_monitor
      root_result_type want;
      root_result_type got;
      int              hold_left;
      bit              hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.root = rsp_tdata[DW-1:0];
            got.steps_taken = rsp_tdata[DW+7:DW];
            got.converged = rsp_tuser;
            if (pending_roots.size() == 0) begin
               $error("unexpected result: root %h steps %0d converged %b",
                      got.root, got.steps_taken, got.converged);
               fail_count++;
            end else begin
               want = pending_roots.pop_front();
               if (got.root !== want.root) begin
                  $error("root: expected %h, got %h", want.root, got.root);
                  fail_count++;
               end
               if (got.steps_taken !== want.steps_taken) begin
                  $error("steps_taken: expected %0d, got %0d",
                         want.steps_taken, got.steps_taken);
                  fail_count++;
               end
               if (got.converged !== want.converged) begin
                  $error("converged: expected %b, got %b", want.converged, got.converged);
                  fail_count++;
               end
            end
            results_seen++;
         end
         // one long hold-off so the block backs up into the request channel
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            case (pace)
               PACE_SLOW_SINK: rsp_tready <= $urandom_range(0, 99) >= 86;
               PACE_SLOW_SOURCE: rsp_tready <= $urandom_range(0, 99) >= 37;
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   initial begin : watchdog
      longint elapsed;
      elapsed = 0;
      while (elapsed < cycle_limit) begin
         @(posedge clock);
         elapsed++;
      end
      $display("[newton_square_root_loop] ERROR");
      $finish;
   end

   // wait until no request is in flight, then let the trailing step finish
   task automatic settle();
      while (radicand_backlog.size() != 0 || req_tvalid || pending_roots.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'({index, 2'b00});
      csr_pwdata <= CSR_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_EPSILON: tolerance_setting = value;
         REG_INIT_EST: start_setting = value[DW-1:0];
         REG_MAX_ITER: step_cap_setting = value[STEP_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] tolerance, input logic [31:0] start,
                            input step_type cap, input pace_type mode);
      settle();
      write_register(REG_EPSILON, tolerance);
      write_register(REG_INIT_EST, start);
      write_register(REG_MAX_ITER, 32'(cap));
      @(negedge clock);
      pace = mode;
      cycle_limit += 1000;
   endtask

   // queue a request and widen the timeout by its worst case
   task automatic issue(input logic [DW-1:0] rad);
      radicand_backlog.push_back(rad);
      cycle_limit += 3 * (83 * longint'(step_cap_setting) + 90) + 400;
   endtask

   initial begin : stimulus
      logic [31:0] tolerance;
      logic [31:0] start;
      step_type    cap;
      pace_type    mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: corners of the radicand
      issue(32'h0);         issue(32'hFFFF_FFFF); issue(32'h1);
      issue(32'h0001_0000); issue(32'h0004_0000); issue(32'h0009_0000);
      issue(32'h8000_0000); issue(32'h7FFF_FFFF); issue(32'h0000_FFFF);

      // no tolerance, zero start value: estimate collapses to zero and reloads one
      configure(32'h0, 32'h0, 8'd255, PACE_SLOW_SINK);
      issue(32'h0); issue(32'h0001_0000);

      // zero step cap: emit after the first check
      configure(32'h0000_1000, 32'hFFFF_FFFF, 8'd0, PACE_SLOW_SINK);
      issue(32'hFFFF_FFFF); issue(32'h0); issue(32'h0002_0000); issue(32'h1234_5678);

      // widest tolerance, smallest start value, single step
      configure(32'hFFFF_FFFF, 32'h1, 8'd1, PACE_SLOW_SINK);
      issue(32'h0); issue(32'hFFFF_FFFF); issue(32'h0064_0000);

      // back to defaults with the widest cap on exact squares
      configure(EPS_RESET, INIT_EST_RESET, 8'd255, PACE_SLOW_SINK);
      issue(32'h0004_0000); issue(32'h0); issue(32'h0019_0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = p < 3 ? PACE_SLOW_SINK : (p < 6 ? PACE_SLOW_SOURCE : PACE_FULL);
         if (p == 0) begin
            tolerance = 32'h0;
            start = 32'h1;
            cap = step_type'($urandom_range(1, 4));
         end else if (p == 1) begin
            tolerance = 32'hFFFF_FFFF;
            start = 32'hFFFF_FFFF;
            cap = 8'd255;
         end else begin
            case ($urandom_range(0, 3))
               0: tolerance = $urandom;
               1: tolerance = $urandom >> $urandom_range(0, 31);
               2: tolerance = 32'hFFFF_FFFF;
               default: tolerance = EPS_RESET;
            endcase
            case ($urandom_range(0, 2))
               0: start = 32'h1;
               1: start = 32'hFFFF_FFFF;
               default: start = $urandom_range(1, 32'hFFFF_FFFF);
            endcase
            cap = $urandom_range(0, 9) < 6 ? step_type'($urandom_range(1, 6))
                                           : step_type'($urandom_range(7, 24));
         end
         configure(tolerance, start, cap, mode);
         for (int n = 0; n < PHASE_ITEMS; n++) issue(pick_radicand());
      end

      settle();
      if (fail_count == 0) begin
         $display("[newton_square_root_loop] OK");
      end else begin
         $display("[newton_square_root_loop] ERROR");
      end
      $finish;
   end

endmodule
